/* hdl/assert_macros.svh */
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/wsfr_pkg.sv */
// Types and constants for the WebSocket frame receiver.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package wsfr_pkg;

	localparam int LENGTH_BITS_DEF = 64;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OPCODE_MASK = 4'hF;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam int TUSER_W = 5;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_CLOSED  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CAUSE_CLOSE  = 2'd0,
		CAUSE_OPCODE = 2'd1,
		CAUSE_CLOSED = 2'd2
	} cause_t;

	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
		logic       bin;
		logic       last;
		cause_t     cause;
	} result_t;

endpackage

`default_nettype wire

/* hdl/wsfr_core.sv */
// Frame parser: header decode, length tracking and payload unmasking.
// Depends on wsfr_pkg; produces one result request per accepted byte at most.
`default_nettype none

module wsfr_core #(
	parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        in_byte,
	output wsfr_pkg::result_t      res
);

	wsfr_pkg::phase_t        phase_q, phase_d;
	logic [3:0]              count_q, count_d;
	logic [3:0]              opcode_q, opcode_d;
	logic                    mask_q, mask_d;
	logic [6:0]              short_q, short_d;
	logic [LENGTH_BITS-1:0]  rem_q, rem_d;
	logic [31:0]             key_q, key_d;
	logic [1:0]              pos_q, pos_d;

	logic [3:0] ext_old, ext_new, total;
	logic [7:0] key_byte;
	logic       fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfr_pkg::PH_HEADER;
			count_q  <= '0;
			opcode_q <= '0;
			mask_q   <= 1'b0;
			short_q  <= '0;
			rem_q    <= '0;
			key_q    <= '0;
			pos_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			short_q  <= short_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			pos_q    <= pos_d;
		end
	end

	always_comb begin
		case (pos_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		short_d  = short_q;
		rem_d    = rem_q;
		key_d    = key_q;
		pos_d    = pos_q;
		ext_old  = (short_q == wsfr_pkg::LEN_EXT16) ? 4'd2 :
			(short_q == wsfr_pkg::LEN_EXT64) ? 4'd8 : 4'd0;
		ext_new  = 4'd0;
		total    = 4'd0;
		fin      = 1'b0;
		res      = '0;
		res.kind = wsfr_pkg::KIND_START;
		res.cause = wsfr_pkg::CAUSE_CLOSE;
		unique case (phase_q)
			wsfr_pkg::PH_HEADER: begin
				if (count_q == 4'd0) begin
					opcode_d = in_byte[3:0] & wsfr_pkg::OPCODE_MASK;
				end else if (count_q == 4'd1) begin
					mask_d  = in_byte[7];
					short_d = in_byte[6:0];
					rem_d   = (in_byte[6:0] < wsfr_pkg::LEN_EXT16) ?
						{{(LENGTH_BITS-7){1'b0}}, in_byte[6:0]} : '0;
				end else if (count_q < 4'd2 + ext_old) begin
					if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0)
						rem_d = '1;
					else
						rem_d = {rem_q[LENGTH_BITS-9:0], in_byte};
				end else begin
					key_d = {key_q[23:0], in_byte};
				end
				count_d = count_q + 4'd1;
				ext_new = (short_d == wsfr_pkg::LEN_EXT16) ? 4'd2 :
					(short_d == wsfr_pkg::LEN_EXT64) ? 4'd8 : 4'd0;
				total   = 4'd2 + ext_new + (mask_d ? 4'd4 : 4'd0);
				if (count_d >= 4'd2 && count_d >= total) begin
					count_d   = 4'd0;
					pos_d     = 2'd0;
					res.valid = 1'b1;
					if (opcode_q == wsfr_pkg::OP_TEXT || opcode_q == wsfr_pkg::OP_BINARY) begin
						res.kind = wsfr_pkg::KIND_START;
						res.bin  = (opcode_q == wsfr_pkg::OP_BINARY);
						res.last = (rem_d == '0);
						phase_d  = (rem_d == '0) ? wsfr_pkg::PH_HEADER : wsfr_pkg::PH_PAYLOAD;
					end else begin
						res.kind  = wsfr_pkg::KIND_ERROR;
						res.cause = (opcode_q == wsfr_pkg::OP_CLOSE) ?
							wsfr_pkg::CAUSE_CLOSE : wsfr_pkg::CAUSE_OPCODE;
						phase_d   = wsfr_pkg::PH_CLOSED;
					end
				end
			end
			wsfr_pkg::PH_PAYLOAD: begin
				fin       = (rem_q[LENGTH_BITS-1:1] == '0);
				res.valid = 1'b1;
				res.kind  = wsfr_pkg::KIND_DATA;
				res.data  = mask_q ? (in_byte ^ key_byte) : in_byte;
				res.last  = fin;
				if (mask_q)
					pos_d = pos_q + 2'd1;
				if (fin) begin
					rem_d   = '0;
					phase_d = wsfr_pkg::PH_HEADER;
					count_d = 4'd0;
				end else begin
					rem_d = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
				end
			end
			default: begin
				res.valid = 1'b1;
				res.kind  = wsfr_pkg::KIND_ERROR;
				res.cause = wsfr_pkg::CAUSE_CLOSED;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/wsfr_out.sv */
// Output register for result requests, with stream handshake.
// Depends on wsfr_pkg; sits between the parser and the master port.
`default_nettype none

module wsfr_out (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  wire wsfr_pkg::result_t               res,
	output logic                                 room,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [7:0]                           m_axis_tdata,
	output logic                                 m_axis_tlast,
	output logic [wsfr_pkg::TUSER_W-1:0]         m_axis_tuser
);

	logic valid_q;
	wsfr_pkg::result_t res_q;

	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= take && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (room && take && res.valid)
			res_q <= res;
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q.data;
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tuser  = {res_q.cause, res_q.bin, res_q.kind};

endmodule

`default_nettype wire

/* hdl/websocket_frame_receiver.sv */
// WebSocket frame receiver top level: parser plus output register.
// A result is registered and is on m_axis in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a result
// waits in the output register and m_axis_tready is low.
// Reset: arst_n clears parse state to header phase and empties the output.
// Depends on wsfr_pkg, wsfr_core, wsfr_out and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_receiver #(
	parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // [7:0] data_byte
	output logic                             m_axis_tlast,  // last
	// [1:0] out_kind, [2] bin_flag, [4:3] err_cause
	output logic [wsfr_pkg::TUSER_W-1:0]     m_axis_tuser
);

	logic take, room;
	wsfr_pkg::result_t res;

	assign s_axis_tready = room;
	assign take = s_axis_tvalid && room;

	wsfr_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_axis_tdata),
		.res     (res)
	);

	wsfr_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.res           (res),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	`ASSERT_IMPLIES(a_err_clean, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[1:0] == wsfr_pkg::KIND_ERROR,
		!m_axis_tlast && !m_axis_tuser[2])
	`ASSERT_IMPLIES(a_data_zero, clk, arst_n,
		m_axis_tvalid && m_axis_tuser[1:0] != wsfr_pkg::KIND_DATA,
		m_axis_tdata == 8'd0)
	`ASSERT_IMPLIES(a_full_blocks, clk, arst_n,
		m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`ASSERT_NEXT(a_closed_err, clk, arst_n,
		m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == wsfr_pkg::KIND_ERROR
			&& s_axis_tvalid,
		m_axis_tvalid && m_axis_tuser[1:0] == wsfr_pkg::KIND_ERROR
			&& m_axis_tuser[4:3] == wsfr_pkg::CAUSE_CLOSED)

endmodule

`default_nettype wire

/* test/websocket_frame_receiver_test.sv */
// Self-checking testbench for websocket_frame_receiver: drives framed byte streams
// with random gaps and output stalls and checks every result against a local parser.
// Depends on wsfr_pkg and the websocket_frame_receiver RTL.
module websocket_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	typedef enum int {
		FORM_SHORT,
		FORM_EXT16,
		FORM_EXT64
	} len_form_t;

	typedef struct packed {
		wsfr_pkg::kind_t  kind;
		logic [7:0]       data;
		logic             bin;
		logic             last;
		wsfr_pkg::cause_t cause;
	} ws_result_t;

	class frame_checker;
		localparam int LEN_W = wsfr_pkg::LENGTH_BITS_DEF;

		wsfr_pkg::phase_t parse_phase;
		logic [3:0]       hdr_idx;
		logic [3:0]       opc;
		logic             masked;
		logic [6:0]       len_code;
		logic [LEN_W-1:0] left_len;
		logic [31:0]      key;
		logic [1:0]       key_pos;
		ws_result_t       due_results[$];
		int               failures;

		function new();
			parse_phase = wsfr_pkg::PH_HEADER;
			hdr_idx = '0;
			opc = '0;
			masked = 1'b0;
			len_code = '0;
			left_len = '0;
			key = '0;
			key_pos = '0;
			failures = 0;
		endfunction

		function int ext_bytes();
			if (len_code == wsfr_pkg::LEN_EXT16)
				return 2;
			if (len_code == wsfr_pkg::LEN_EXT64)
				return 8;
			return 0;
		endfunction

		function void push(wsfr_pkg::kind_t k, logic [7:0] d, logic bin, logic lst,
				wsfr_pkg::cause_t c);
			ws_result_t r;
			r.kind = k;
			r.data = d;
			r.bin = bin;
			r.last = lst;
			r.cause = c;
			due_results = {due_results, r};
		endfunction

		function void take_byte(logic [7:0] b);
			int         idx;
			int         sh;
			logic [7:0] d;
			logic       fin;
			case (parse_phase)
				wsfr_pkg::PH_HEADER: begin
					idx = int'(hdr_idx);
					if (idx == 0) begin
						opc = b[3:0];
					end else if (idx == 1) begin
						masked = b[7];
						len_code = b[6:0];
						if (len_code < wsfr_pkg::LEN_EXT16)
							left_len = {{(LEN_W-7){1'b0}}, len_code};
						else
							left_len = '0;
					end else if (idx < 2 + ext_bytes()) begin
						// saturate once the value would overflow
						if (left_len[LEN_W-1 -: 8] != 8'h00)
							left_len = '1;
						else
							left_len = {left_len[LEN_W-9:0], b};
					end else begin
						key = {key[23:0], b};
					end
					hdr_idx = hdr_idx + 4'd1;
					if (hdr_idx >= 2 && hdr_idx >= 2 + ext_bytes() + (masked ? 4 : 0)) begin
						hdr_idx = '0;
						key_pos = '0;
						if (opc == wsfr_pkg::OP_TEXT || opc == wsfr_pkg::OP_BINARY) begin
							push(wsfr_pkg::KIND_START, 8'h00, opc == wsfr_pkg::OP_BINARY,
								left_len == '0, wsfr_pkg::CAUSE_CLOSE);
							parse_phase = (left_len == '0) ? wsfr_pkg::PH_HEADER :
								wsfr_pkg::PH_PAYLOAD;
						end else begin
							push(wsfr_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0,
								(opc == wsfr_pkg::OP_CLOSE) ? wsfr_pkg::CAUSE_CLOSE :
									wsfr_pkg::CAUSE_OPCODE);
							parse_phase = wsfr_pkg::PH_CLOSED;
						end
					end
				end
				wsfr_pkg::PH_PAYLOAD: begin
					d = b;
					if (masked) begin
						sh = 24 - 8 * int'(key_pos);
						d = b ^ key[sh +: 8];
						key_pos = key_pos + 2'd1;
					end
					fin = (left_len <= 1);
					if (fin) begin
						left_len = '0;
						parse_phase = wsfr_pkg::PH_HEADER;
						hdr_idx = '0;
					end else begin
						left_len = left_len - 1;
					end
					push(wsfr_pkg::KIND_DATA, d, 1'b0, fin, wsfr_pkg::CAUSE_CLOSE);
				end
				default: begin
					push(wsfr_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b0, wsfr_pkg::CAUSE_CLOSED);
				end
			endcase
		endfunction

		task report(string what);
			failures++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_output(logic [7:0] data, logic lst, logic [wsfr_pkg::TUSER_W-1:0] user);
			ws_result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result tuser=%h tdata=%h tlast=%b", user, data, lst));
				return;
			end
			want = due_results.pop_front();
			if (user[1:0] != want.kind)
				report($sformatf("out_kind %0d, want %0d", user[1:0], want.kind));
			if (data != want.data)
				report($sformatf("data_byte %h, want %h", data, want.data));
			if (user[2] != want.bin)
				report($sformatf("binary flag %b, want %b", user[2], want.bin));
			if (lst != want.last)
				report($sformatf("last %b, want %b", lst, want.last));
			if (user[4:3] != want.cause)
				report($sformatf("err_cause %0d, want %0d", user[4:3], want.cause));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [7:0]                   s_axis_tdata;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [7:0]                   m_axis_tdata;
	logic                         m_axis_tlast;
	logic [wsfr_pkg::TUSER_W-1:0] m_axis_tuser;

	frame_checker book;
	int           bytes_sent = 0;
	int           idle_cycles = 0;
	int           stall_left = 0;
	bit           quiet_in = 1'b0;
	bit           quiet_out = 1'b0;

	websocket_frame_receiver uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(quiet_in);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		book.take_byte(b);
		bytes_sent++;
	endtask

	task send_frame(input logic [3:0] opc, input bit masked, input len_form_t form,
			input logic [63:0] len, input logic [31:0] key, input bit extremes);
		logic [6:0] code;
		logic [3:0] flags;
		logic [7:0] pb;
		int         i;
		quiet_in = ($urandom_range(0, 3) == 0);
		quiet_out = ($urandom_range(0, 3) == 0);
		if (form == FORM_SHORT)
			code = len[6:0];
		else if (form == FORM_EXT16)
			code = wsfr_pkg::LEN_EXT16;
		else
			code = wsfr_pkg::LEN_EXT64;
		// FIN and RSV bits are don't-care
		flags = 4'($urandom_range(0, 15));
		send_byte({flags, opc});
		send_byte({masked, code});
		if (form == FORM_EXT16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == FORM_EXT64) begin
			for (i = 7; i >= 0; i--)
				send_byte(len[8*i +: 8]);
		end
		if (masked) begin
			for (i = 3; i >= 0; i--)
				send_byte(key[8*i +: 8]);
		end
		for (i = 0; i < len; i++) begin
			pb = 8'($urandom_range(0, 255));
			if (extremes && i == 0)
				pb = 8'h00;
			else if (extremes && i == 1)
				pb = 8'hFF;
			send_byte(pb);
		end
	endtask

	task send_random_frame();
		logic [3:0]  opc;
		logic [63:0] n;
		logic [31:0] key;
		len_form_t   form;
		bit          masked;
		int          r;
		opc = ($urandom_range(0, 1) == 1) ? wsfr_pkg::OP_BINARY : wsfr_pkg::OP_TEXT;
		masked = ($urandom_range(0, 3) != 0);
		key = $urandom;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			form = FORM_SHORT;
			r = $urandom_range(0, 99);
			if (r < 10)
				n = '0;
			else if (r < 70)
				n = 64'($urandom_range(1, 8));
			else if (r < 95)
				n = 64'($urandom_range(9, 40));
			else
				n = 64'($urandom_range(100, 125));
		end else begin
			form = (r < 90) ? FORM_EXT16 : FORM_EXT64;
			if ($urandom_range(0, 9) == 0)
				n = 64'($urandom_range(256, 300));
			else
				n = 64'($urandom_range(0, 40));
		end
		send_frame(opc, masked, form, n, key, 1'b0);
	endtask

	// output side: random backpressure and result check
	always @(posedge clk) begin : out_side
		int n;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				book.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				n = pick_gap(quiet_out);
				stall_left <= (n > 0) ? n - 1 : 0;
				m_axis_tready <= (n == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[websocket_frame_receiver] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : main
		logic [3:0] end_opc;
		logic [7:0] pb;
		book = new();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		m_axis_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty frames, masked and plain payloads, both extended lengths
		send_frame(wsfr_pkg::OP_TEXT, 1'b0, FORM_SHORT, 64'd0, 32'h0, 1'b0);
		send_frame(wsfr_pkg::OP_BINARY, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF, 1'b0);
		send_frame(wsfr_pkg::OP_TEXT, 1'b1, FORM_SHORT, 64'd5, 32'hFFFF_FFFF, 1'b1);
		send_frame(wsfr_pkg::OP_BINARY, 1'b0, FORM_SHORT, 64'd2, 32'h0, 1'b1);
		send_frame(wsfr_pkg::OP_TEXT, 1'b1, FORM_EXT16, 64'd0, $urandom, 1'b0);
		send_frame(wsfr_pkg::OP_BINARY, 1'b1, FORM_EXT16, 64'd3, 32'h0, 1'b1);
		send_frame(wsfr_pkg::OP_TEXT, 1'b0, FORM_EXT64, 64'd1, 32'h0, 1'b1);
		send_frame(wsfr_pkg::OP_BINARY, 1'b1, FORM_EXT64, 64'd0, $urandom, 1'b0);

		while (bytes_sent < 370)
			send_random_frame();

		// close or unsupported opcode ends the stream; later bytes are errors
		do
			end_opc = 4'($urandom_range(0, 15));
		while (end_opc == wsfr_pkg::OP_TEXT || end_opc == wsfr_pkg::OP_BINARY);
		if ($urandom_range(0, 1) == 1)
			end_opc = wsfr_pkg::OP_CLOSE;
		send_frame(end_opc, 1'($urandom_range(0, 1)), FORM_SHORT,
			64'($urandom_range(0, 6)), $urandom, 1'b0);
		repeat ($urandom_range(4, 12)) begin
			pb = 8'($urandom_range(0, 255));
			send_byte(pb);
		end
		s_axis_tvalid <= 1'b0;

		while (book.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (book.failures == 0)
			$display("[websocket_frame_receiver] OK");
		else
			$display("[websocket_frame_receiver] ERROR");
		$finish;
	end
endmodule
